// ===== hdl/cln_pkg.sv =====
package cln_pkg;

    // request kinds carried in the input tuser field
    localparam logic [2:0] REQ_RAW   = 3'd0;
    localparam logic [2:0] REQ_CHAR  = 3'd1;
    localparam logic [2:0] REQ_GOTO  = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_HOME  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_LINE_COUNT  = 3'd0;
    localparam logic [2:0] CFG_LINE0_START = 3'd1;
    localparam logic [2:0] CFG_LINE1_START = 3'd2;
    localparam logic [2:0] CFG_LINE2_START = 3'd3;
    localparam logic [2:0] CFG_LINE3_START = 3'd4;

    // configuration reset values
    localparam logic [2:0] LINE_COUNT_RST  = 3'd2;
    localparam logic [6:0] LINE0_START_RST = 7'd0;
    localparam logic [6:0] LINE1_START_RST = 7'd64;
    localparam logic [6:0] LINE2_START_RST = 7'd20;
    localparam logic [6:0] LINE3_START_RST = 7'd84;

    // display command bytes
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // line counts that give go-to-position a meaning
    localparam logic [2:0] LINES_ONE  = 3'd1;
    localparam logic [2:0] LINES_TWO  = 3'd2;
    localparam logic [2:0] LINES_FOUR = 3'd4;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 8;

    typedef logic [3:0][6:0] line_start_t;

    // decoded request: the byte to send and the line tracking update
    typedef struct packed {
        logic       emit;
        logic       rs;
        logic [7:0] data;
        logic       line_wr;
        logic [1:0] line_next;
    } dec_t;

endpackage

// ===== hdl/cln_decode.sv =====
module cln_decode
    import cln_pkg::*;
(
    input  logic [2:0]  req_type,
    input  logic [7:0]  byte_value,
    input  logic [1:0]  row,
    input  logic [6:0]  column,
    input  logic [2:0]  line_count,
    input  line_start_t line_start,
    input  logic [1:0]  current_line,
    output dec_t        dec
);

    logic       nl_wrap;
    logic [1:0] nl_line;
    logic [1:0] goto_line;
    logic       goto_ok;
    logic [7:0] goto_addr;
    logic [7:0] nl_addr;

    always_comb
    begin
        nl_wrap = (line_count == 3'd0)
               || ({1'b0, current_line} >= (line_count - 3'd1))
               || (current_line == 2'd3);
        nl_line = nl_wrap ? 2'd0 : current_line + 2'd1;
        nl_addr = CMD_SET_ADDR + {1'b0, line_start[nl_line]};

        goto_line = row;
        goto_ok   = 1'b0;
        if (line_count == LINES_ONE)
        begin
            goto_line = 2'd0;
            goto_ok   = 1'b1;
        end
        else if (line_count == LINES_TWO)
        begin
            goto_ok = (row < 2'd2);
        end
        else if (line_count == LINES_FOUR)
        begin
            goto_ok = 1'b1;
        end
        // sum wraps modulo 256
        goto_addr = CMD_SET_ADDR + {1'b0, line_start[goto_line]} + {1'b0, column};
    end

    always_comb
    begin
        dec = '0;
        unique case (req_type)
            REQ_RAW:
            begin
                dec.emit = 1'b1;
                dec.data = byte_value;
            end
            REQ_CHAR:
            begin
                dec.emit = 1'b1;
                if (byte_value == CHAR_NEWLINE)
                begin
                    dec.data      = nl_addr;
                    dec.line_wr   = 1'b1;
                    dec.line_next = nl_line;
                end
                else
                begin
                    dec.rs   = 1'b1;
                    dec.data = byte_value;
                end
            end
            REQ_GOTO:
            begin
                dec.emit = goto_ok;
                dec.data = goto_addr;
            end
            REQ_CLEAR:
            begin
                dec.emit    = 1'b1;
                dec.data    = CMD_CLEAR;
                dec.line_wr = 1'b1;
            end
            REQ_HOME:
            begin
                dec.emit    = 1'b1;
                dec.data    = CMD_HOME;
                dec.line_wr = 1'b1;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

endmodule

// ===== hdl/char_lcd_nibble_writer.sv =====
// Flow: an accepted item waits in the input stage register and is loaded into the output
// register when that is free; the output presents the high nibble, then the low nibble.
// Rate: one nibble per cycle while m_axis_tready is high; the single output channel
// carries each byte as two nibbles, and the next byte can load as the low nibble is taken.
// Items that send nothing leave the input stage without waiting for the output stage.
// Reset (rst_n low, asynchronous): pipeline empty, tracked line 0, registers
// line_count 2 and line starts 0, 64, 20, 84.
module char_lcd_nibble_writer
    import cln_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [6:0]            cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // byte_value[7:0], row[9:8], column[16:10]
    input  logic [2:0]            s_axis_tuser,   // req_type[2:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // nibble[3:0]
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser    // reg_select[0]
);

    logic [2:0]  line_count_reg;
    line_start_t line_start_reg;
    logic [1:0]  line_reg;

    logic        in_valid_reg;
    logic [2:0]  in_type_reg;
    logic [7:0]  in_byte_reg;
    logic [1:0]  in_row_reg;
    logic [6:0]  in_col_reg;

    logic        out_valid_reg;
    logic        out_phase_reg;
    logic        out_rs_reg;
    logic [7:0]  out_byte_reg;

    dec_t        dec;
    logic        out_free;
    logic        in_advance;
    logic        out_load;
    logic [3:0]  nibble;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg    <= LINE_COUNT_RST;
            line_start_reg[0] <= LINE0_START_RST;
            line_start_reg[1] <= LINE1_START_RST;
            line_start_reg[2] <= LINE2_START_RST;
            line_start_reg[3] <= LINE3_START_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_COUNT:  line_count_reg    <= cfg_wdata[2:0];
                CFG_LINE0_START: line_start_reg[0] <= cfg_wdata;
                CFG_LINE1_START: line_start_reg[1] <= cfg_wdata;
                CFG_LINE2_START: line_start_reg[2] <= cfg_wdata;
                CFG_LINE3_START: line_start_reg[3] <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    cln_decode u_decode (
        .req_type     (in_type_reg),
        .byte_value   (in_byte_reg),
        .row          (in_row_reg),
        .column       (in_col_reg),
        .line_count   (line_count_reg),
        .line_start   (line_start_reg),
        .current_line (line_reg),
        .dec          (dec)
    );

    assign out_free      = !out_valid_reg || (m_axis_tready && out_phase_reg);
    assign in_advance    = in_valid_reg && (!dec.emit || out_free);
    assign out_load      = in_valid_reg && dec.emit && out_free;
    assign s_axis_tready = !in_valid_reg || in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            line_reg     <= 2'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            // commit line tracking when the item leaves the input stage
            if (in_advance && dec.line_wr)
            begin
                line_reg <= dec.line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_type_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata[7:0];
            in_row_reg  <= s_axis_tdata[9:8];
            in_col_reg  <= s_axis_tdata[16:10];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_phase_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_phase_reg <= 1'b0;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            // advance to the low nibble, or drop after it
            out_valid_reg <= !out_phase_reg;
            out_phase_reg <= !out_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= dec.data;
            out_rs_reg   <= dec.rs;
        end
    end

    assign nibble        = out_phase_reg ? out_byte_reg[3:0] : out_byte_reg[7:4];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 4){1'b0}}, nibble};
    assign m_axis_tlast  = out_phase_reg;
    assign m_axis_tuser  = out_rs_reg;

endmodule

// ===== hdl/cln_checker.sv =====
module cln_checker
    import cln_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser
);

    // no item offered in the cycle after a reset edge
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    // a stalled item holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled output item changed");

    // high nibble is always followed at once by its low nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tlast))
        else $error("low nibble missing after high nibble");

    // both nibbles of a byte carry the same register select
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> $stable(m_axis_tuser))
        else $error("register select changed within a byte");

    // upper tdata bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:4] == '0))
        else $error("padding bits set in output item");

endmodule

bind char_lcd_nibble_writer cln_checker u_cln_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cln_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 105;
    localparam int RANDOM_PHASES  = 8;
    localparam int MAX_NOTES      = 40;

    // request kinds the block must ignore
    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_MID   = 3'd6;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

    // line counts without a go-to-position meaning
    localparam logic [2:0] LINES_NONE  = 3'd0;
    localparam logic [2:0] LINES_THREE = 3'd3;
    localparam logic [2:0] LINES_SEVEN = 3'd7;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } nibble_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] b;
        logic [1:0] row;
        logic [6:0] col;
        logic       typed;
        logic       sends;
        logic       rs;
        logic [7:0] code;
    } dir_row_t;

    localparam int DIR_N = 24;

    // starts from reset: line count 2, line starts 0, 64, 20, 84, tracked line 0
    dir_row_t directed [DIR_N] = '{
        '{REQ_RAW,   8'h00, 2'd0, 7'd0,   1'b1, 1'b1, 1'b0, 8'h00},
        '{REQ_RAW,   8'hFF, 2'd3, 7'd127, 1'b1, 1'b1, 1'b0, 8'hFF},
        '{REQ_CHAR,  8'h41, 2'd0, 7'd0,   1'b1, 1'b1, 1'b1, 8'h41},
        '{REQ_CHAR,  8'hFF, 2'd3, 7'd127, 1'b1, 1'b1, 1'b1, 8'hFF},
        '{REQ_CHAR,  8'h00, 2'd0, 7'd0,   1'b1, 1'b1, 1'b1, 8'h00},
        '{REQ_CHAR,  8'h0A, 2'd0, 7'd0,   1'b1, 1'b1, 1'b0, 8'hC0},
        '{REQ_CHAR,  8'h0A, 2'd3, 7'd127, 1'b1, 1'b1, 1'b0, 8'h80},
        '{REQ_GOTO,  8'h00, 2'd0, 7'd0,   1'b1, 1'b1, 1'b0, 8'h80},
        '{REQ_GOTO,  8'hFF, 2'd1, 7'd127, 1'b1, 1'b1, 1'b0, 8'h3F},
        '{REQ_GOTO,  8'h00, 2'd2, 7'd5,   1'b1, 1'b0, 1'b0, 8'h00},
        '{REQ_GOTO,  8'hFF, 2'd3, 7'd127, 1'b1, 1'b0, 1'b0, 8'h00},
        '{REQ_GOTO,  8'h5A, 2'd1, 7'd10,  1'b0, 1'b0, 1'b0, 8'h00},
        '{REQ_CLEAR, 8'hAA, 2'd3, 7'd127, 1'b1, 1'b1, 1'b0, 8'h01},
        '{REQ_HOME,  8'h55, 2'd2, 7'd42,  1'b1, 1'b1, 1'b0, 8'h02},
        '{REQ_CHAR,  8'h0A, 2'd0, 7'd0,   1'b1, 1'b1, 1'b0, 8'hC0},
        '{REQ_CLEAR, 8'h0A, 2'd0, 7'd0,   1'b1, 1'b1, 1'b0, 8'h01},
        '{REQ_CHAR,  8'h0A, 2'd1, 7'd3,   1'b1, 1'b1, 1'b0, 8'hC0},
        '{REQ_HOME,  8'hFF, 2'd3, 7'd127, 1'b1, 1'b1, 1'b0, 8'h02},
        '{REQ_CHAR,  8'h0A, 2'd0, 7'd0,   1'b0, 1'b0, 1'b0, 8'h00},
        '{REQ_BAD_FIRST, 8'h41, 2'd0, 7'd0, 1'b1, 1'b0, 1'b0, 8'h00},
        '{REQ_BAD_MID,   8'h0A, 2'd1, 7'd1, 1'b1, 1'b0, 1'b0, 8'h00},
        '{REQ_BAD_LAST, 8'hFF, 2'd3, 7'd127, 1'b1, 1'b0, 1'b0, 8'h00},
        '{REQ_CHAR,  8'h0B, 2'd2, 7'd64,  1'b0, 1'b0, 1'b0, 8'h00},
        '{REQ_GOTO,  8'h00, 2'd0, 7'd127, 1'b0, 1'b0, 1'b0, 8'h00}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = CFG_LINE_COUNT;
    logic [6:0]            cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // byte_value[7:0], row[9:8], column[16:10]
    logic [2:0]            s_axis_tuser = REQ_RAW; // req_type[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // nibble[3:0]
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;        // reg_select[0]

    // shadow of the block's registers and line tracking
    logic [2:0]   line_count = LINE_COUNT_RST;
    line_start_t  line_start = {LINE3_START_RST, LINE2_START_RST,
                                LINE1_START_RST, LINE0_START_RST};
    logic [1:0]   cur_line = '0;

    nibble_t nibbles_due [$];
    nibble_t got;

    int  cycles = 0;
    int  errors = 0;
    int  requests_sent = 0;
    int  nibbles_checked = 0;
    int  newlines_sent = 0;
    int  gotos_sent = 0;
    int  settings_used = 1;
    bit  squeeze = 1'b0;
    bit  steady = 1'b0;

    char_lcd_nibble_writer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d nibbles outstanding",
                     cycles, nibbles_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        if (errors < MAX_NOTES)
            $display("cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Work out the byte a request puts on the bus and advance the tracked line.
    function automatic logic lcd_command(input logic [2:0] kind, input logic [7:0] b,
                                         input logic [1:0] row, input logic [6:0] col,
                                         output logic rs, output logic [7:0] code);
        logic [1:0] line;
        logic       sends;
        line  = row;
        sends = 1'b1;
        rs    = 1'b0;
        code  = b;
        case (kind)
            REQ_RAW: ;
            REQ_CHAR:
                if (b == CHAR_NEWLINE)
                begin
                    // wrap after the last configured line; two bits cap it at line 3
                    if (line_count == LINES_NONE || int'(cur_line) >= int'(line_count) - 1
                        || cur_line == 2'd3)
                        cur_line = 2'd0;
                    else
                        cur_line = cur_line + 2'd1;
                    code = CMD_SET_ADDR + {1'b0, line_start[cur_line]};
                end
                else
                    rs = 1'b1;
            REQ_GOTO:
            begin
                if (line_count == LINES_ONE)
                    line = 2'd0;
                else if (line_count == LINES_TWO)
                    sends = (row < 2'd2);
                else if (line_count != LINES_FOUR)
                    sends = 1'b0;
                code = CMD_SET_ADDR + {1'b0, line_start[line]} + {1'b0, col};
            end
            REQ_CLEAR:
            begin
                cur_line = 2'd0;
                code = CMD_CLEAR;
            end
            REQ_HOME:
            begin
                cur_line = 2'd0;
                code = CMD_HOME;
            end
            default:
                sends = 1'b0;
        endcase
        return sends;
    endfunction

    task automatic send_request(input logic [2:0] kind, input logic [7:0] b,
                                input logic [1:0] row, input logic [6:0] col,
                                input logic typed, input logic t_sends,
                                input logic t_rs, input logic [7:0] t_code);
        logic       sends;
        logic       rs;
        logic [7:0] code;
        int         gap;
        gap = 0;
        if (!steady && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, col, row, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // accepted at this edge
        sends = lcd_command(kind, b, row, col, rs, code);
        if (typed)
        begin
            sends = t_sends;
            rs    = t_rs;
            code  = t_code;
        end
        if (sends)
        begin
            nibbles_due.push_back('{rs: rs, nib: code[7:4], last: 1'b0});
            nibbles_due.push_back('{rs: rs, nib: code[3:0], last: 1'b1});
        end
        requests_sent++;
        if (kind == REQ_CHAR && b == CHAR_NEWLINE)
            newlines_sent++;
        if (kind == REQ_GOTO)
            gotos_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_LINE_COUNT:  line_count    = val[2:0];
            CFG_LINE0_START: line_start[0] = val;
            CFG_LINE1_START: line_start[1] = val;
            CFG_LINE2_START: line_start[2] = val;
            CFG_LINE3_START: line_start[3] = val;
            default: ;
        endcase
    endtask

    // Drain the block, then load a new line layout.
    task automatic program_lines(input logic [2:0] count, input line_start_t starts);
        s_axis_tvalid <= 1'b0;
        while (nibbles_due.size() != 0)
            @(posedge clk);
        // requests that send nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_LINE_COUNT, {4'd0, count});
        write_reg(CFG_LINE0_START, starts[0]);
        write_reg(CFG_LINE1_START, starts[1]);
        write_reg(CFG_LINE2_START, starts[2]);
        write_reg(CFG_LINE3_START, starts[3]);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        logic [2:0] kind;
        logic [7:0] b;
        logic [1:0] row;
        logic [6:0] col;
        int         pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            b    = 8'($urandom);
            row  = 2'($urandom);
            col  = 7'($urandom);
            if (pick < 20)
                kind = REQ_RAW;
            else if (pick < 50)
            begin
                kind = REQ_CHAR;
                if ($urandom_range(0, 3) == 0)
                    b = CHAR_NEWLINE;
            end
            else if (pick < 78)
            begin
                kind = REQ_GOTO;
                if ($urandom_range(0, 5) == 0)
                    col = $urandom_range(0, 1) ? 7'h7F : 7'h00;
            end
            else if (pick < 86)
                kind = REQ_CLEAR;
            else if (pick < 94)
                kind = REQ_HOME;
            else
                kind = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
            send_request(kind, b, row, col, 1'b0, 1'b0, 1'b0, 8'h00);
        end
    endtask

    initial
    begin
        logic [2:0]  lc;
        line_start_t st;
        wait (rst_n);
        @(posedge clk);
        for (int i = 0; i < DIR_N; i++)
            send_request(directed[i].kind, directed[i].b, directed[i].row, directed[i].col,
                         directed[i].typed, directed[i].sends, directed[i].rs,
                         directed[i].code);
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            lc = LINES_FOUR;
            for (int k = 0; k < 4; k++)
                st[k] = 7'($urandom_range(0, 127));
            case (ph)
                0:
                begin
                    lc = LINES_ONE;
                    st = {4{7'h7F}};
                end
                1: st = {4{7'h00}};
                2: st = {LINE3_START_RST, LINE2_START_RST, LINE1_START_RST, LINE0_START_RST};
                3: lc = LINES_THREE;
                4: lc = LINES_NONE;
                5: lc = LINES_SEVEN;
                6: lc = LINES_TWO;
                default: steady = 1'b1;
            endcase
            program_lines(lc, st);
            // back up the output while items keep coming
            if (ph == 2)
                squeeze = 1'b1;
            run_random(PHASE_ITEMS);
        end
        s_axis_tvalid <= 1'b0;
        while (nibbles_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests over %0d line layouts (%0d newlines, %0d go-to requests)",
                 requests_sent, settings_used, newlines_sent, gotos_sent);
        $display("%0d nibbles checked, %0d mismatches", nibbles_checked, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // output side: random stalls plus one long hold-off
    initial
    begin
        bit held;
        int gap;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !held)
            begin
                m_axis_tready <= 1'b0;
                for (int hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
                m_axis_tready <= 1'b1;
                held = 1'b1;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (nibbles_due.size() == 0)
                note_mismatch($sformatf("nibble %h arrived with none pending", m_axis_tdata));
            else
            begin
                got = nibbles_due.pop_front();
                if (m_axis_tuser !== got.rs)
                    note_mismatch($sformatf("reg_select %b, want %b", m_axis_tuser, got.rs));
                if (m_axis_tdata[3:0] !== got.nib)
                    note_mismatch($sformatf("nibble %h, want %h", m_axis_tdata[3:0], got.nib));
                if (m_axis_tlast !== got.last)
                    note_mismatch($sformatf("last %b, want %b", m_axis_tlast, got.last));
                nibbles_checked++;
            end
        end
    end

endmodule
